// ===== hdl/tilt_frame_check_and_hold_detect_macros.svh =====
`ifndef TILT_FRAME_CHECK_AND_HOLD_DETECT_MACROS_SVH
`define TILT_FRAME_CHECK_AND_HOLD_DETECT_MACROS_SVH

// same-cycle implication, checked out of reset
`define TFCHD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfchd same-cycle check failed");

// next-cycle implication, checked out of reset
`define TFCHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfchd next-cycle check failed");

`endif

// ===== hdl/tfchd_pkg.sv =====
package tfchd_pkg;

    localparam int FRAME_BUFFER_BYTES = 32;
    localparam int COUNT_W            = $clog2(FRAME_BUFFER_BYTES + 1);
    localparam int HDR_BYTES          = 11;
    localparam int HDR_IDX_W          = $clog2(HDR_BYTES);
    localparam int CRC_BYTES          = 9;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
    localparam logic [7:0]  BYTE_COUNT_SIX  = 8'h06;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_CMD   = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [7:0] CHR_ONE  = 8'h31;
    localparam logic [7:0] CHR_LS   = 8'h73;
    localparam logic [7:0] CHR_US   = 8'h53;
    localparam logic [7:0] CHR_ZERO = 8'h30;
    localparam logic [7:0] CHR_LR   = 8'h72;
    localparam logic [7:0] CHR_UR   = 8'h52;

    localparam logic [2:0] OP_BYTE  = 3'd0;
    localparam logic [2:0] OP_TICK  = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_STOP  = 3'd3;
    localparam logic [2:0] OP_ERROR = 3'd4;
    localparam logic [2:0] OP_NONE  = 3'd5;

    localparam logic [1:0] CFG_STATION = 2'd0;
    localparam logic [1:0] CFG_WINDOW  = 2'd1;
    localparam logic [1:0] CFG_HOLD    = 2'd2;

    localparam logic [7:0]  RST_STATION = 8'd5;
    localparam logic [14:0] RST_WINDOW  = 15'd500;
    localparam logic [15:0] RST_HOLD    = 16'd5000;

    localparam int OUT_W = 72;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       last;
    } t_op;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

endpackage

// ===== hdl/tfchd_front.sv =====
module tfchd_front (
    input  logic                  i_s_tvalid,
    input  logic [7:0]            i_s_tdata,   // data_byte[7:0]
    input  logic [1:0]            i_s_tuser,   // kind[1:0]
    input  logic                  i_s_tlast,
    input  tfchd_pkg::t_q_stat    i_q_stat,
    output logic                  o_s_tready,
    output logic                  o_push,
    output tfchd_pkg::t_op        o_op
);

    logic [2:0] w_op;

    always_comb begin
        case (i_s_tuser)
            tfchd_pkg::KIND_BYTE:  w_op = tfchd_pkg::OP_BYTE;
            tfchd_pkg::KIND_TICK:  w_op = tfchd_pkg::OP_TICK;
            tfchd_pkg::KIND_CMD: begin
                if (i_s_tdata == tfchd_pkg::CHR_ONE || i_s_tdata == tfchd_pkg::CHR_LS ||
                    i_s_tdata == tfchd_pkg::CHR_US) begin
                    w_op = tfchd_pkg::OP_START;
                end else if (i_s_tdata == tfchd_pkg::CHR_ZERO ||
                             i_s_tdata == tfchd_pkg::CHR_LR ||
                             i_s_tdata == tfchd_pkg::CHR_UR) begin
                    w_op = tfchd_pkg::OP_STOP;
                end else begin
                    w_op = tfchd_pkg::OP_NONE;
                end
            end
            tfchd_pkg::KIND_ERROR: w_op = tfchd_pkg::OP_ERROR;
            default:               w_op = tfchd_pkg::OP_NONE;
        endcase
    end

    assign o_s_tready = !i_q_stat.full;
    assign o_push     = i_s_tvalid && !i_q_stat.full;
    assign o_op.op    = w_op;
    assign o_op.data  = i_s_tdata;
    assign o_op.last  = i_s_tlast && (i_s_tuser == tfchd_pkg::KIND_BYTE);

endmodule

// ===== hdl/tfchd_queue.sv =====
module tfchd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tfchd_pkg::t_op     i_op,
    input  logic               i_pop,
    output tfchd_pkg::t_op     o_head,
    output logic               o_head_valid,
    output tfchd_pkg::t_q_stat o_stat
);

    tfchd_pkg::t_op                  r_mem [tfchd_pkg::QUEUE_DEPTH];
    logic [tfchd_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [tfchd_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [tfchd_pkg::QCNT_W-1:0]    r_count;
    logic                            w_full;

    assign w_full = (r_count == tfchd_pkg::QCNT_W'(tfchd_pkg::QUEUE_DEPTH));

    function automatic logic [tfchd_pkg::QPTR_W-1:0] f_adv(
        input logic [tfchd_pkg::QPTR_W-1:0] p
    );
        if (p == tfchd_pkg::QPTR_W'(tfchd_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_adv(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_adv(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_head_valid = (r_count != '0);
    assign o_stat.full  = w_full;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

endmodule

// ===== hdl/tfchd_back.sv =====
module tfchd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tfchd_pkg::t_op                i_head,
    input  logic                          i_head_valid,
    output logic                          o_pop,
    input  logic                          i_cfg_valid,
    input  logic [1:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tfchd_pkg::OUT_W-1:0]   o_m_tdata
);

    logic [7:0]  r_station;
    logic [14:0] r_window;
    logic [15:0] r_hold_ticks;

    logic [tfchd_pkg::COUNT_W-1:0] r_count, n_count;
    logic [7:0]  r_bytes [tfchd_pkg::HDR_BYTES];
    logic [7:0]  n_bytes [tfchd_pkg::HDR_BYTES];
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_roll, n_roll, r_pitch, n_pitch, r_yaw, n_yaw;
    logic [15:0] r_broll, n_broll, r_bpitch, n_bpitch, r_byaw, n_byaw;
    logic        r_run, n_run, r_done, n_done, r_inwin, n_inwin, r_lamp, n_lamp;
    logic [15:0] r_hold, n_hold;
    logic        w_acc, w_rej, w_all_in;
    logic        r_out_valid;
    logic [tfchd_pkg::OUT_W-1:0] r_out_data;

    function automatic logic [15:0] f_crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ tfchd_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic f_in_win(input logic [15:0] a, input logic [15:0] b,
                                      input logic [14:0] w);
        logic signed [17:0] v;
        logic signed [17:0] lo;
        logic signed [17:0] hi;
        v  = $signed({{2{a[15]}}, a});
        lo = $signed({{2{b[15]}}, b}) - $signed({3'b000, w});
        hi = $signed({{2{b[15]}}, b}) + $signed({3'b000, w});
        return (v > lo) && (v < hi);
    endfunction

    assign o_pop = i_head_valid && (!r_out_valid || i_m_tready);
    assign w_all_in = f_in_win(r_roll, r_broll, r_window) &&
                      f_in_win(r_pitch, r_bpitch, r_window) &&
                      f_in_win(r_yaw, r_byaw, r_window);

    always_comb begin
        n_count  = r_count;
        n_bytes  = r_bytes;
        n_crc    = r_crc;
        n_roll   = r_roll;
        n_pitch  = r_pitch;
        n_yaw    = r_yaw;
        n_broll  = r_broll;
        n_bpitch = r_bpitch;
        n_byaw   = r_byaw;
        n_run    = r_run;
        n_done   = r_done;
        n_inwin  = r_inwin;
        n_lamp   = r_lamp;
        n_hold   = r_hold;
        w_acc    = 1'b0;
        w_rej    = 1'b0;
        case (i_head.op)
            tfchd_pkg::OP_BYTE: begin
                if (r_count < tfchd_pkg::COUNT_W'(tfchd_pkg::FRAME_BUFFER_BYTES)) begin
                    if (r_count < tfchd_pkg::COUNT_W'(tfchd_pkg::HDR_BYTES)) begin
                        n_bytes[r_count[tfchd_pkg::HDR_IDX_W-1:0]] = i_head.data;
                    end
                    if (r_count < tfchd_pkg::COUNT_W'(tfchd_pkg::CRC_BYTES)) begin
                        n_crc = f_crc_byte(r_crc, i_head.data);
                    end
                    n_count = r_count + 1'b1;
                end
                if (i_head.last) begin
                    if (n_count >= tfchd_pkg::COUNT_W'(tfchd_pkg::HDR_BYTES) &&
                        n_bytes[0] == r_station &&
                        n_bytes[1] == tfchd_pkg::FUNC_READ_INPUT &&
                        n_bytes[2] == tfchd_pkg::BYTE_COUNT_SIX &&
                        {n_bytes[10], n_bytes[9]} == n_crc) begin
                        n_roll  = {n_bytes[3], n_bytes[4]};
                        n_pitch = {n_bytes[5], n_bytes[6]};
                        n_yaw   = {n_bytes[7], n_bytes[8]};
                        w_acc   = 1'b1;
                    end else begin
                        w_rej   = 1'b1;
                    end
                    n_count = '0;
                    n_crc   = tfchd_pkg::CRC_INIT;
                end
            end
            tfchd_pkg::OP_TICK: begin
                if (r_run) begin
                    if (w_all_in) begin
                        n_lamp = 1'b1;
                        if (!r_inwin) begin
                            n_inwin = 1'b1;
                            n_hold  = '0;
                        end else if (r_hold != 16'hFFFF) begin
                            n_hold  = r_hold + 1'b1;
                        end
                        if (n_hold >= r_hold_ticks) begin
                            n_done  = 1'b1;
                            n_run   = 1'b0;
                            n_inwin = 1'b0;
                            n_lamp  = 1'b0;
                        end
                    end else begin
                        n_inwin = 1'b0;
                        n_lamp  = 1'b0;
                        n_hold  = '0;
                    end
                end
            end
            tfchd_pkg::OP_START: begin
                n_broll  = r_roll;
                n_bpitch = r_pitch;
                n_byaw   = r_yaw;
                n_run    = 1'b1;
                n_done   = 1'b0;
                n_inwin  = 1'b0;
                n_lamp   = 1'b0;
                n_hold   = '0;
            end
            tfchd_pkg::OP_STOP: begin
                n_run   = 1'b0;
                n_inwin = 1'b0;
                n_lamp  = 1'b0;
            end
            tfchd_pkg::OP_ERROR: begin
                n_count = '0;
                n_crc   = tfchd_pkg::CRC_INIT;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bytes    <= n_bytes;
            r_out_data <= {3'b000, n_hold, r_done & 1'b0 | n_done, n_run, n_lamp,
                           w_rej, w_acc, n_yaw, n_pitch, n_roll};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station    <= tfchd_pkg::RST_STATION;
            r_window     <= tfchd_pkg::RST_WINDOW;
            r_hold_ticks <= tfchd_pkg::RST_HOLD;
            r_count      <= '0;
            r_crc        <= tfchd_pkg::CRC_INIT;
            r_roll       <= '0;
            r_pitch      <= '0;
            r_yaw        <= '0;
            r_broll      <= '0;
            r_bpitch     <= '0;
            r_byaw       <= '0;
            r_run        <= 1'b0;
            r_done       <= 1'b0;
            r_inwin      <= 1'b0;
            r_lamp       <= 1'b0;
            r_hold       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tfchd_pkg::CFG_STATION: r_station    <= i_cfg_data[7:0];
                    tfchd_pkg::CFG_WINDOW:  r_window     <= i_cfg_data[14:0];
                    tfchd_pkg::CFG_HOLD:    r_hold_ticks <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (o_pop) begin
                r_count     <= n_count;
                r_crc       <= n_crc;
                r_roll      <= n_roll;
                r_pitch     <= n_pitch;
                r_yaw       <= n_yaw;
                r_broll     <= n_broll;
                r_bpitch    <= n_bpitch;
                r_byaw      <= n_byaw;
                r_run       <= n_run;
                r_done      <= n_done;
                r_inwin     <= n_inwin;
                r_lamp      <= n_lamp;
                r_hold      <= n_hold;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== hdl/tilt_frame_check_and_hold_detect.sv =====
// Tilt sensor frame checker and hold detector.
// Slave stream: one request per item; tuser carries the kind (sensor byte,
// millisecond tick, terminal command, line error), tdata the byte, tlast the
// end-of-frame mark on sensor bytes. Every request yields exactly one result.
// Master stream: tdata carries the stored angles, the frame accept/reject
// flags, lamp, detecting, settled and the hold tick count.
// Config channel: index 0 station address, 1 window half width, 2 hold ticks;
// always ready; it must be written only while the block is idle, and
// the block itself does not enforce this.
// Throughput: one request per cycle while the receiver takes results, set by
// the back stage that does the CRC byte update and window compares.
// A two-entry request queue sits between classifier and back stage, and the
// result register parts the master side; when the receiver stalls the queue
// fills and s_tready drops.
// Reset (synchronous, active low) empties the queue, drops the pending
// result, loads the register defaults and clears frame and hold state.
`include "tilt_frame_check_and_hold_detect_macros.svh"

module tilt_frame_check_and_hold_detect (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic [1:0]  i_s_tuser,   // [1:0] kind
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] roll_angle, [31:16] pitch_angle, [47:32] yaw_angle,
    // [48] frame_accepted, [49] frame_rejected, [50] lamp_on, [51] detecting,
    // [52] settled_flag, [68:53] hold_elapsed, [71:69] zero
    output logic [71:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    tfchd_pkg::t_q_stat w_q_stat;
    tfchd_pkg::t_op     w_push_op;
    tfchd_pkg::t_op     w_head;
    logic               w_push;
    logic               w_pop;
    logic               w_head_valid;
    logic               w_flags_ok;
    logic               w_q_at_depth;
    logic               w_push_empty;

    assign o_cfg_ready = 1'b1;

    tfchd_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .i_q_stat   (w_q_stat),
        .o_s_tready (o_s_tready),
        .o_push     (w_push),
        .o_op       (w_push_op)
    );

    tfchd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_op         (w_push_op),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .o_stat       (w_q_stat)
    );

    tfchd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata)
    );

    assign w_flags_ok   = !(o_m_tdata[48] && o_m_tdata[49]) &&
                          (!o_m_tdata[50] || o_m_tdata[51]) &&
                          !(o_m_tdata[51] && o_m_tdata[52]);
    assign w_q_at_depth = (w_q_stat.count == tfchd_pkg::QCNT_W'(tfchd_pkg::QUEUE_DEPTH));
    assign w_push_empty = w_push && w_q_stat.empty;

    `TFCHD_ASSERT_NOW(a_flags_consistent, i_clk, i_rst_n, o_m_tvalid, w_flags_ok)
    `TFCHD_ASSERT_NOW(a_ready_when_room, i_clk, i_rst_n, !o_s_tready, w_q_at_depth)
    `TFCHD_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, w_push_empty, !w_q_stat.empty)

endmodule

// ===== tb/tilt_status_board_pkg.sv =====
package tilt_status_board_pkg;

    import tfchd_pkg::*;

    typedef struct packed {
        logic [2:0]         pad;
        logic [15:0]        hold_elapsed;
        logic               settled_flag;
        logic               detecting;
        logic               lamp_on;
        logic               frame_rejected;
        logic               frame_accepted;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } tilt_status_t;

    function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    class tilt_status_board;

        logic [7:0]         cfg_station;
        logic [14:0]        cfg_window;
        logic [15:0]        cfg_hold;

        int                 frame_len;
        logic [7:0]         frame_bytes [HDR_BYTES];
        logic [15:0]        frame_crc;
        logic signed [15:0] roll, pitch, yaw;
        logic signed [15:0] base_roll, base_pitch, base_yaw;
        logic               running, settled, in_win, lamp;
        logic [15:0]        hold_cnt;

        tilt_status_t       expected_status [$];
        int                 mismatch_count;

        function new();
            cfg_station    = RST_STATION;
            cfg_window     = RST_WINDOW;
            cfg_hold       = RST_HOLD;
            frame_len      = 0;
            foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
            frame_crc      = CRC_INIT;
            roll           = '0;
            pitch          = '0;
            yaw            = '0;
            base_roll      = '0;
            base_pitch     = '0;
            base_yaw       = '0;
            running        = 1'b0;
            settled        = 1'b0;
            in_win         = 1'b0;
            lamp           = 1'b0;
            hold_cnt       = '0;
            mismatch_count = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_STATION: cfg_station = val[7:0];
                CFG_WINDOW:  cfg_window  = val[14:0];
                CFG_HOLD:    cfg_hold    = val;
                default: ;
            endcase
        endfunction

        function bit in_band(logic signed [15:0] a, logic signed [15:0] b);
            int v, c, w;
            v = a;
            c = b;
            w = int'(cfg_window);
            return (v > c - w) && (v < c + w);
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void note_request(logic [1:0] kind, logic [7:0] data, logic last);
            tilt_status_t r;
            r = '0;
            case (kind)
                KIND_BYTE: begin
                    if (frame_len < FRAME_BUFFER_BYTES) begin
                        if (frame_len < HDR_BYTES) frame_bytes[frame_len] = data;
                        if (frame_len < CRC_BYTES) frame_crc = crc16_update(frame_crc, data);
                        frame_len++;
                    end
                    if (last) begin
                        if (frame_len >= HDR_BYTES && frame_bytes[0] == cfg_station &&
                            frame_bytes[1] == FUNC_READ_INPUT &&
                            frame_bytes[2] == BYTE_COUNT_SIX &&
                            {frame_bytes[10], frame_bytes[9]} == frame_crc) begin
                            roll  = {frame_bytes[3], frame_bytes[4]};
                            pitch = {frame_bytes[5], frame_bytes[6]};
                            yaw   = {frame_bytes[7], frame_bytes[8]};
                            r.frame_accepted = 1'b1;
                        end else begin
                            r.frame_rejected = 1'b1;
                        end
                        frame_len = 0;
                        frame_crc = CRC_INIT;
                    end
                end
                KIND_TICK: begin
                    if (running) begin
                        if (in_band(roll, base_roll) && in_band(pitch, base_pitch) &&
                            in_band(yaw, base_yaw)) begin
                            lamp = 1'b1;
                            if (!in_win) begin
                                in_win   = 1'b1;
                                hold_cnt = '0;
                            end else if (hold_cnt != 16'hFFFF) begin
                                hold_cnt++;
                            end
                            if (hold_cnt >= cfg_hold) begin
                                settled = 1'b1;
                                running = 1'b0;
                                in_win  = 1'b0;
                                lamp    = 1'b0;
                            end
                        end else begin
                            in_win   = 1'b0;
                            lamp     = 1'b0;
                            hold_cnt = '0;
                        end
                    end
                end
                KIND_CMD: begin
                    if (data == CHR_ONE || data == CHR_LS || data == CHR_US) begin
                        base_roll  = roll;
                        base_pitch = pitch;
                        base_yaw   = yaw;
                        running    = 1'b1;
                        settled    = 1'b0;
                        in_win     = 1'b0;
                        lamp       = 1'b0;
                        hold_cnt   = '0;
                    end else if (data == CHR_ZERO || data == CHR_LR || data == CHR_UR) begin
                        running = 1'b0;
                        in_win  = 1'b0;
                        lamp    = 1'b0;
                    end
                end
                default: begin
                    frame_len = 0;
                    frame_crc = CRC_INIT;
                end
            endcase
            r.roll_angle   = roll;
            r.pitch_angle  = pitch;
            r.yaw_angle    = yaw;
            r.lamp_on      = lamp;
            r.detecting    = running;
            r.settled_flag = settled;
            r.hold_elapsed = hold_cnt;
            expected_status.push_back(r);
        endfunction

        function void compare_field(string name, longint exp_val, longint act_val);
            if (exp_val != act_val) begin
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
                mismatch_count++;
            end
        endfunction

        function void check_status(logic [71:0] raw);
            tilt_status_t e, a;
            a = raw;
            if (expected_status.size() == 0) begin
                $error("result with no pending request: %h", raw);
                mismatch_count++;
                return;
            end
            e = expected_status.pop_front();
            compare_field("roll_angle", longint'(e.roll_angle), longint'(a.roll_angle));
            compare_field("pitch_angle", longint'(e.pitch_angle), longint'(a.pitch_angle));
            compare_field("yaw_angle", longint'(e.yaw_angle), longint'(a.yaw_angle));
            compare_field("frame_accepted", e.frame_accepted, a.frame_accepted);
            compare_field("frame_rejected", e.frame_rejected, a.frame_rejected);
            compare_field("lamp_on", e.lamp_on, a.lamp_on);
            compare_field("detecting", e.detecting, a.detecting);
            compare_field("settled_flag", e.settled_flag, a.settled_flag);
            compare_field("hold_elapsed", e.hold_elapsed, a.hold_elapsed);
            compare_field("pad", e.pad, a.pad);
        endfunction

    endclass

endpackage

// ===== tb/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import tfchd_pkg::*;
    import tilt_status_board_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int BLOCK_ITEMS  = 206;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [71:0] o_m_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    tilt_status_board sb;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          sent_items;
    logic [7:0]  cur_station;
    int          cur_window;
    int          cur_center;
    logic [7:0]  frame_q [$];

    int station_tab [5] = '{5, 0, 255, 165, 90};
    int window_tab  [5] = '{500, 1, 32767, 200, 16384};
    int hold_tab    [5] = '{3, 0, 65535, 1, 10};
    int center_tab  [5] = '{0, -32768, 32767, 1234, -20000};

    tilt_frame_check_and_hold_detect dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_request(i_s_tuser, i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) sb.check_status(o_m_tdata);
        end
    end

    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_item(input logic [1:0] kind, input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= data;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_register(idx, val);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic void build_frame(logic [7:0] station, logic [15:0] r,
                                        logic [15:0] p, logic [15:0] y);
        logic [15:0] crc;
        frame_q.delete();
        frame_q.push_back(station);
        frame_q.push_back(FUNC_READ_INPUT);
        frame_q.push_back(BYTE_COUNT_SIX);
        frame_q.push_back(r[15:8]);
        frame_q.push_back(r[7:0]);
        frame_q.push_back(p[15:8]);
        frame_q.push_back(p[7:0]);
        frame_q.push_back(y[15:8]);
        frame_q.push_back(y[7:0]);
        crc = CRC_INIT;
        for (int i = 0; i < CRC_BYTES; i++) crc = crc16_update(crc, frame_q[i]);
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
    endfunction

    function automatic logic [15:0] pick_angle();
        int r, dev, w;
        w = cur_window;
        r = $urandom_range(99);
        if (r < 5) return r[0] ? 16'h7FFF : 16'h8000;
        if (r < 15) return 16'($urandom);
        if (r < 25) begin
            case ($urandom_range(3))
                0: dev = w;
                1: dev = -w;
                2: dev = w - 1;
                default: dev = 1 - w;
            endcase
        end else if (r < 75) begin
            dev = int'($urandom_range(2 * (w - 1))) - (w - 1);
        end else begin
            dev = int'($urandom_range(4 * w)) - 2 * w;
        end
        return 16'(cur_center + dev);
    endfunction

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++) begin
            send_item(KIND_BYTE, frame_q[i], i == frame_q.size() - 1);
        end
    endtask

    task automatic build_good();
        build_frame(cur_station, pick_angle(), pick_angle(), pick_angle());
    endtask

    task automatic run_episode();
        int r, n, cut;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 40) begin
            build_good();
            if ($urandom_range(9) == 0) begin
                n = $urandom_range(1, 23);
                repeat (n) frame_q.push_back(8'($urandom));
            end
            send_frame();
        end else if (r < 65) begin
            n = $urandom_range(1, 8);
            repeat (n) send_item(KIND_TICK, 8'($urandom), 1'($urandom));
        end else if (r < 75) begin
            case ($urandom_range(2))
                0: c = CHR_ONE;
                1: c = CHR_LS;
                default: c = CHR_US;
            endcase
            send_item(KIND_CMD, c, 1'($urandom));
        end else if (r < 80) begin
            case ($urandom_range(2))
                0: c = CHR_ZERO;
                1: c = CHR_LR;
                default: c = CHR_UR;
            endcase
            send_item(KIND_CMD, c, 1'($urandom));
        end else if (r < 84) begin
            do c = 8'($urandom);
            while (c inside {CHR_ONE, CHR_LS, CHR_US, CHR_ZERO, CHR_LR, CHR_UR});
            send_item(KIND_CMD, c, 1'($urandom));
        end else if (r < 93) begin
            build_good();
            case ($urandom_range(7))
                0: frame_q[0] = frame_q[0] ^ 8'($urandom_range(1, 255));
                1: frame_q[1] = frame_q[1] ^ 8'($urandom_range(1, 255));
                2: frame_q[2] = frame_q[2] ^ 8'($urandom_range(1, 255));
                3: frame_q[9 + $urandom_range(1)] ^= 8'($urandom_range(1, 255));
                4: frame_q[$urandom_range(3, 8)] ^= 8'($urandom_range(1, 255));
                5: begin
                    cut = $urandom_range(1, 10);
                    while (frame_q.size() > cut) void'(frame_q.pop_back());
                end
                6: begin
                    cut = $urandom_range(1, 10);
                    for (int i = 0; i < cut; i++) send_item(KIND_BYTE, frame_q[i], 1'b0);
                    send_item(KIND_ERROR, 8'($urandom), 1'($urandom));
                end
                default: begin
                    for (int i = 0; i < 5; i++) send_item(KIND_BYTE, frame_q[i], 1'b0);
                    send_item(KIND_TICK, 8'($urandom), 1'b1);
                    for (int i = 0; i < 5; i++) void'(frame_q.pop_front());
                end
            endcase
            send_frame();
        end else begin
            send_item(2'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        int sel;
        int target;
        sb          = new();
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = KIND_BYTE;
        i_s_tlast   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_STATION;
        i_cfg_data  = '0;
        sent_items  = 0;
        send_idle_pct = 20;
        recv_idle_pct = 46;
        cur_station = RST_STATION;
        cur_window  = int'(RST_WINDOW);
        cur_center  = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(KIND_TICK, 8'h00, 1'b1);
        send_item(KIND_CMD, CHR_US, 1'b0);
        send_item(KIND_TICK, 8'h00, 1'b0);
        send_item(KIND_TICK, 8'hFF, 1'b0);
        send_item(KIND_BYTE, RST_STATION, 1'b0);
        send_item(KIND_BYTE, FUNC_READ_INPUT, 1'b1);
        send_item(KIND_BYTE, 8'hFF, 1'b0);
        send_item(KIND_ERROR, 8'hFF, 1'b1);
        build_frame(RST_STATION, 16'h7FFF, 16'h8000, 16'h0001);
        send_frame();
        send_item(KIND_TICK, 8'h00, 1'b0);
        send_item(KIND_CMD, CHR_LS, 1'b1);
        send_item(KIND_TICK, 8'h00, 1'b0);
        send_item(KIND_CMD, 8'h00, 1'b0);
        send_item(KIND_CMD, CHR_ZERO, 1'b0);
        send_item(KIND_CMD, CHR_LR, 1'b0);
        send_item(KIND_CMD, CHR_UR, 1'b0);
        send_item(KIND_CMD, CHR_ONE, 1'b0);

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 46;
                end
                1: begin
                    send_idle_pct = 46;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < 3; k++) begin
                sel = (mode * 3 + k) % 5;
                wait_drained();
                write_reg(CFG_STATION, 16'(station_tab[sel]));
                write_reg(CFG_WINDOW, 16'(window_tab[sel]));
                write_reg(CFG_HOLD, 16'(hold_tab[sel]));
                i_cfg_valid <= 1'b0;
                cur_station = 8'(station_tab[sel]);
                cur_window  = window_tab[sel];
                cur_center  = center_tab[sel];
                target = sent_items + BLOCK_ITEMS;
                while (sent_items < target) run_episode();
            end
        end

        wait_drained();
        repeat (12) @(negedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
